### src/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg: shared type, constants and function of the TCP checksum stream.
// Holds the byte item type, the pseudo header constants and the
// end-around-carry adder that is used by the checksum core.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned ACC_W    = WORD_W + 1;
    localparam int unsigned ADDR_CNT_W = 4;

    localparam logic [ADDR_CNT_W-1:0] ADDR_BYTES  = 4'd8;
    localparam logic [WORD_W-1:0]     SKIP_FIRST  = 16'd16;
    localparam logic [WORD_W-1:0]     SKIP_SECOND = 16'd17;
    localparam logic [WORD_W-1:0]     PROTO_TCP   = 16'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_item;

    // Ones-complement add with end-around carry; the result stays below 2^17.
    function automatic logic [ACC_W-1:0] oc_add(input logic [ACC_W-1:0] acc,
                                                input logic [ACC_W-1:0] val);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + {1'b0, val};
        return ACC_W'({2'b00, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[ACC_W:WORD_W]});
    endfunction

endpackage

### src/tcp_checksum_stream_unit.sv
// ----------------------------------------------------------------------------
// tcp_checksum_stream_unit: streaming TCP checksum with the IPv4 pseudo header.
// Accepts one byte per cycle: eight address bytes, then the TCP segment; the
// byte flagged by tlast yields one 16-bit checksum in the result register. The
// sustained rate is one byte per clock, set by the single accumulator update
// between the input register and the result register; a full result register
// that is not taken stalls only a last byte.
// ----------------------------------------------------------------------------
module tcp_checksum_stream_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] checksum
);

    cts_pkg::t_item in_item;
    cts_pkg::t_item reg_item;
    logic           reg_valid;
    logic           advance;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    cts_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (reg_valid),
        .o_item    (reg_item)
    );

    cts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (reg_valid),
        .i_item      (reg_item),
        .o_advance   (advance),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_checksum  (m_axis_tdata)
    );

endmodule

### src/cts_in_stage.sv
// ----------------------------------------------------------------------------
// cts_in_stage: input register of the TCP checksum stream.
// Captures one byte request per cycle and holds it until the core takes it.
// ----------------------------------------------------------------------------
module cts_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cts_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output cts_pkg::t_item o_item
);

    logic           r_valid;
    cts_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### src/cts_core.sv
// ----------------------------------------------------------------------------
// cts_core: running sum, byte counters and result register.
// Adds each registered byte but segment bytes 16 and 17 into the ones-complement
// sum and, on the last byte, adds the pseudo header terms, folds and registers the checksum.
// ----------------------------------------------------------------------------
module cts_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cts_pkg::t_item              i_item,
    output logic                        o_advance,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cts_pkg::WORD_W-1:0]  o_checksum
);

    logic [cts_pkg::ACC_W-1:0]      r_acc;
    logic [cts_pkg::ADDR_CNT_W-1:0] r_addr_cnt;
    logic [cts_pkg::WORD_W-1:0]     r_seg_idx;
    logic                           r_out_valid;
    logic [cts_pkg::WORD_W-1:0]     r_checksum;

    logic [cts_pkg::ACC_W-1:0]      n_acc;
    logic [cts_pkg::WORD_W-1:0]     n_seg_idx;
    logic                           is_addr;
    logic                           pos_odd;
    logic                           add_en;
    logic [cts_pkg::ACC_W-1:0]      part;
    logic [cts_pkg::ACC_W-1:0]      sum_proto;
    logic [cts_pkg::ACC_W-1:0]      sum_len;
    logic [cts_pkg::ACC_W-1:0]      fold1;
    logic [cts_pkg::ACC_W-1:0]      fold2;
    logic                           out_free;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_advance = i_valid && (!i_item.last_byte || out_free);

    always_comb begin
        is_addr = (r_addr_cnt < cts_pkg::ADDR_BYTES);
        pos_odd = is_addr ? r_addr_cnt[0] : r_seg_idx[0];
        part    = pos_odd ? {9'd0, i_item.data_byte} : {1'b0, i_item.data_byte, 8'd0};
        add_en  = is_addr || ((r_seg_idx != cts_pkg::SKIP_FIRST) &&
                              (r_seg_idx != cts_pkg::SKIP_SECOND));
        n_acc     = add_en ? cts_pkg::oc_add(r_acc, part) : r_acc;
        n_seg_idx = is_addr ? r_seg_idx : r_seg_idx + 16'd1;
        sum_proto = cts_pkg::oc_add(n_acc, {1'b0, cts_pkg::PROTO_TCP});
        sum_len   = cts_pkg::oc_add(sum_proto, {1'b0, n_seg_idx});
        fold1     = {1'b0, sum_len[15:0]} + {16'd0, sum_len[16]};
        fold2     = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_addr_cnt  <= '0;
            r_seg_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_advance) begin
                if (i_item.last_byte) begin
                    r_acc       <= '0;
                    r_addr_cnt  <= '0;
                    r_seg_idx   <= '0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_acc     <= n_acc;
                    r_seg_idx <= n_seg_idx;
                    if (is_addr) begin
                        r_addr_cnt <= r_addr_cnt + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_item.last_byte) begin
            r_checksum <= ~fold2[15:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;

    a_addr_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr_cnt <= cts_pkg::ADDR_BYTES)
        else $error("address byte count above eight");

    a_seg_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg_idx != '0) |-> (r_addr_cnt == cts_pkg::ADDR_BYTES))
        else $error("segment byte counted before the addresses completed");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && i_item.last_byte) |=>
            (r_out_valid && r_addr_cnt == '0 && r_seg_idx == '0 && r_acc == '0))
        else $error("state not cleared after the last byte");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tcp_checksum_stream_unit.
// Streams packets of bytes into the unit. The bytes are eight address bytes
// followed by a TCP segment. The bench keeps its own running ones-complement
// sum of the pseudo header and the segment, and compares every checksum the
// unit returns against that sum. Traffic runs with sender and receiver
// stalls, and includes short and odd-length packets.
// ----------------------------------------------------------------------------
module testbench;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] checksum

    cts_pkg::t_item pending_bytes[$];
    logic [15:0]    expected_sums[$];

    logic [16:0] run_sum    = '0;
    logic [3:0]  addr_seen  = '0;
    logic [15:0] seg_index  = '0;

    int send_idle_pct = 23;
    int recv_idle_pct = 87;
    int mismatches    = 0;
    int bytes_taken   = 0;
    int sums_checked  = 0;

    tcp_checksum_stream_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [16:0] eac_add(input logic [16:0] a, input logic [16:0] b);
        logic [17:0] s;
        s = {1'b0, a} + {1'b0, b};
        return {1'b0, s[15:0]} + {15'd0, s[17:16]};
    endfunction

    task automatic absorb_byte(input logic [7:0] data, input logic last);
        logic [16:0] total;
        logic [16:0] part;
        if (addr_seen < cts_pkg::ADDR_BYTES) begin
            part = addr_seen[0] ? {9'd0, data} : {1'b0, data, 8'd0};
            run_sum = eac_add(run_sum, part);
            addr_seen = addr_seen + 4'd1;
        end else begin
            if (seg_index != cts_pkg::SKIP_FIRST && seg_index != cts_pkg::SKIP_SECOND) begin
                part = seg_index[0] ? {9'd0, data} : {1'b0, data, 8'd0};
                run_sum = eac_add(run_sum, part);
            end
            seg_index = seg_index + 16'd1;
        end
        if (last) begin
            total = eac_add(run_sum, {1'b0, cts_pkg::PROTO_TCP});
            total = eac_add(total, {1'b0, seg_index});
            total = {1'b0, total[15:0]} + {16'd0, total[16]};
            total = {1'b0, total[15:0]} + {16'd0, total[16]};
            expected_sums.push_back(~total[15:0]);
            run_sum = '0;
            addr_seen = '0;
            seg_index = '0;
        end
    endtask

    always @(posedge i_clk) begin
        cts_pkg::t_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data_byte;
                s_axis_tlast  <= nxt.last_byte;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: expected no checksum, got %h", $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_sums.pop_front();
                    sums_checked++;
                    if (want !== m_axis_tdata) begin
                        $display("%0t: checksum expected %h, got %h", $time, want,
                                 m_axis_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic queue_packet(input int n_bytes, input int fill);
        cts_pkg::t_item it;
        for (int k = 0; k < n_bytes; k++) begin
            it.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            it.last_byte = (k == n_bytes - 1);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic drain;
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_sums.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_bytes,
                             input int n_pkts);
        int queued;
        int pkts;
        int len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queued = 0;
        pkts = 0;
        while (queued < n_bytes || pkts < n_pkts) begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(1, 8);
            else
                len = 8 + $urandom_range(0, 40);
            queue_packet(len, -1);
            queued += len;
            pkts++;
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A lone zero byte ends inside the address bytes, then an all-ones
        // packet with an odd segment that runs past the old checksum field.
        queue_packet(1, 8'h00);
        queue_packet(8 + 19, 8'hFF);

        run_phase(23, 87, 155, 4);
        run_phase(87, 23, 155, 4);
        run_phase(0, 0, 155, 4);

        repeat (10) @(posedge i_clk);
        $display("Checked %0d checksums over %0d bytes with stalls on both sides.",
                 sums_checked, bytes_taken);
        $display("Packets included address-only, odd-length and full-rate segments.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
src/cts_pkg.sv
src/cts_in_stage.sv
src/cts_core.sv
src/tcp_checksum_stream_unit.sv
tb/testbench.sv
